FILE: rtl/core/fshl_pkg.sv
// Shared widths, types and helper functions of the stepped fan level block.
package fshl_pkg;

	localparam int TEMP_W      = 10;
	localparam int LEVEL_W     = 3;
	localparam int RPM_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int NUM_REGS    = 7;
	localparam int LEVELS_DEF  = 7;
	localparam int BYTE_W      = 8;
	localparam int RPM_LSB     = 48;

	// Byte offsets of the threshold fields in one level register.
	localparam int ON_CPU_LSB  = 0;
	localparam int ON_REG_LSB  = 8;
	localparam int ON_CHG_LSB  = 16;
	localparam int OFF_CPU_LSB = 24;
	localparam int OFF_REG_LSB = 32;
	localparam int OFF_CHG_LSB = 40;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [CFG_DATA_W-1:0]    level_word_t;
	typedef logic [RPM_W-1:0]         rpm_t;

	// Direction of the change between the stored and the new reading.
	typedef struct packed {
		logic fell;
		logic rose;
	} walk_ctl_t;

	// Sign-extends a threshold byte to the temperature width.
	function automatic temp_t sbyte_ext(input logic [BYTE_W-1:0] b);
		return {{(TEMP_W - BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

endpackage

FILE: rtl/core/fshl_lane.sv
// One level lane: compares a reading against the on and off points of one level.
module fshl_lane (
	input  fshl_pkg::temp_t       t_cpu,
	input  fshl_pkg::temp_t       t_reg,
	input  fshl_pkg::temp_t       t_chg,
	input  fshl_pkg::level_word_t level_word,
	output logic                  go_up,
	output logic                  go_down
);
	import fshl_pkg::*;

	temp_t on_cpu, on_reg, on_chg;
	temp_t off_cpu, off_reg, off_chg;

	assign on_cpu  = sbyte_ext(level_word[ON_CPU_LSB  +: BYTE_W]);
	assign on_reg  = sbyte_ext(level_word[ON_REG_LSB  +: BYTE_W]);
	assign on_chg  = sbyte_ext(level_word[ON_CHG_LSB  +: BYTE_W]);
	assign off_cpu = sbyte_ext(level_word[OFF_CPU_LSB +: BYTE_W]);
	assign off_reg = sbyte_ext(level_word[OFF_REG_LSB +: BYTE_W]);
	assign off_chg = sbyte_ext(level_word[OFF_CHG_LSB +: BYTE_W]);

	// The cpu alone can push the level up; the 5V and charger sensors only together.
	assign go_up   = (t_cpu > on_cpu) || ((t_reg > on_reg) && (t_chg > on_chg));
	assign go_down = (t_cpu < off_cpu) && (t_reg < off_reg) && (t_chg < off_chg);

endmodule

FILE: rtl/core/fshl_merge.sv
// Merge stage: turns the per-level lane flags into the next fan level.
module fshl_merge #(
	parameter int LEVELS = fshl_pkg::LEVELS_DEF,
	parameter int LW     = $clog2(LEVELS)
) (
	input  logic [LW-1:0]       lv_now,
	input  fshl_pkg::walk_ctl_t ctl,
	input  logic [LEVELS-1:0]   up_vec,
	input  logic [LEVELS-1:0]   dn_vec,
	output logic [LW-1:0]       lv_next
);
	import fshl_pkg::*;

	logic [LW-1:0] lv_up;
	logic [LW-1:0] lv_dn;

	// Walking up stops at the first level at or above the current one whose
	// on points are not exceeded; running off the top clamps to the top level.
	always_comb begin
		lv_up = LW'(LEVELS - 1);
		for (int j = LEVELS - 1; j >= 0; j--) begin
			if ((LW'(j) >= lv_now) && !up_vec[j]) begin
				lv_up = LW'(j);
			end
		end
	end

	// Walking down stops at the highest level at or below the current one
	// whose off points are not all above the reading, or at level zero.
	always_comb begin
		lv_dn = '0;
		for (int j = 0; j < LEVELS; j++) begin
			if ((LW'(j) <= lv_now) && ((j == 0) || !dn_vec[j])) begin
				lv_dn = LW'(j);
			end
		end
	end

	always_comb begin
		priority if (ctl.fell) begin
			lv_next = lv_dn;
		end else if (ctl.rose) begin
			lv_next = lv_up;
		end else begin
			lv_next = lv_now;
		end
	end

endmodule

FILE: rtl/core/fan_step_hysteresis_level.sv
// Top level of the stepped fan curve with hysteresis for fan channel 0.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | to block  | in_valid/in_stall  | cpu_temp, temp_regulator, charger_temp,
//           |           |                    | powered
//   out     | from block| out_valid/out_stall| target_rpm, fan_level
//   cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data (one level register)
//
// A powered item is first registered into the compare stage; there the level lanes and
// the merge stage pick the new level and load the output register.
// in_stall is high only while an item sits in the compare stage, so no new item is taken
// then; the item waits there while a stalled result holds the output register.
// An item with powered low is accepted and dropped without a result.
// Reset clears the level, the stored reading and all level registers; cfg_ready stays high.
module fan_step_hysteresis_level #(
	parameter int LEVELS = fshl_pkg::LEVELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  fshl_pkg::temp_t                cpu_temp,
	input  fshl_pkg::temp_t                temp_regulator,
	input  fshl_pkg::temp_t                charger_temp,
	input  logic                           powered,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fshl_pkg::RPM_W-1:0]     target_rpm,
	output logic [fshl_pkg::LEVEL_W-1:0]   fan_level,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fshl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fshl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fshl_pkg::*;

	localparam int LW = $clog2(LEVELS);

	// Level table, one register per level. Each lane reads its own entry only.
	level_word_t   level_reg_q [LEVELS];

	// Persistent state: current level and the previous reading.
	logic [LW-1:0] level_now_q;
	temp_t         last_cpu_q, last_reg_q, last_chg_q;

	// Compare stage.
	logic          s1_valid_q;
	temp_t         t_cpu_s1, t_reg_s1, t_chg_s1;

	// Output register.
	logic          out_valid_q;
	rpm_t          rpm_q;
	logic [LW-1:0] fan_level_q;

	logic              in_acc;
	logic              s1_done;
	walk_ctl_t         ctl;
	logic [LEVELS-1:0] up_vec;
	logic [LEVELS-1:0] dn_vec;
	logic [LW-1:0]     lv_next;

	assign cfg_ready = 1'b1;
	assign in_stall  = s1_valid_q;
	assign in_acc    = in_valid && !in_stall;

	// The compare stage hands its result on as soon as the output register is free
	// or is being emptied in the same cycle.
	assign s1_done = s1_valid_q && (!out_valid_q || !out_stall);

	// Configuration writes. Only the registers of the table exist; a level
	// without a register, if any, keeps reading as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				level_reg_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < LEVELS; i++) begin
				if ((i < NUM_REGS) && (int'(cfg_index) == i)) begin
					level_reg_q[i] <= cfg_data;
				end
			end
		end
	end

	// Stage one: capture a powered reading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc && powered) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && powered) begin
			t_cpu_s1 <= cpu_temp;
			t_reg_s1 <= temp_regulator;
			t_chg_s1 <= charger_temp;
		end
	end

	// Any sensor falling takes precedence over any sensor rising.
	assign ctl.fell = (t_cpu_s1 < last_cpu_q) || (t_reg_s1 < last_reg_q) ||
	                  (t_chg_s1 < last_chg_q);
	assign ctl.rose = (t_cpu_s1 > last_cpu_q) || (t_reg_s1 > last_reg_q) ||
	                  (t_chg_s1 > last_chg_q);

	// One lane per level evaluates the on and off conditions in parallel.
	for (genvar g = 0; g < LEVELS; g++) begin : g_lane
		fshl_lane u_lane (
			.t_cpu      (t_cpu_s1),
			.t_reg      (t_reg_s1),
			.t_chg      (t_chg_s1),
			.level_word (level_reg_q[g]),
			.go_up      (up_vec[g]),
			.go_down    (dn_vec[g])
		);
	end

	fshl_merge #(
		.LEVELS (LEVELS),
		.LW     (LW)
	) u_merge (
		.lv_now  (level_now_q),
		.ctl     (ctl),
		.up_vec  (up_vec),
		.dn_vec  (dn_vec),
		.lv_next (lv_next)
	);

	// State update when the compare stage completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_now_q <= '0;
			last_cpu_q  <= '0;
			last_reg_q  <= '0;
			last_chg_q  <= '0;
		end else if (s1_done) begin
			level_now_q <= lv_next;
			last_cpu_q  <= t_cpu_s1;
			last_reg_q  <= t_reg_s1;
			last_chg_q  <= t_chg_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			rpm_q       <= level_reg_q[lv_next][RPM_LSB +: RPM_W];
			fan_level_q <= lv_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign target_rpm = rpm_q;
	assign fan_level  = LEVEL_W'(fan_level_q);

endmodule

FILE: rtl/core/fshl_checker.sv
// Port-level checker for the stepped fan level block, bound to the top level.
module fshl_checker #(
	parameter int LEVELS = fshl_pkg::LEVELS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         powered,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [fshl_pkg::RPM_W-1:0]   target_rpm,
	input logic [fshl_pkg::LEVEL_W-1:0] fan_level
);
	import fshl_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// A stalled result stays and does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target_rpm) && $stable(fan_level))
		else $error("stalled result changed or dropped");

	// The reported level never exceeds the top level.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(fan_level) < LEVELS))
		else $error("fan level beyond top level");

	// A powered item occupies the compare stage, so the next item waits.
	a_busy_after_powered: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && powered |=> in_stall)
		else $error("powered item did not hold off the next item");

	// An unpowered item produces no result.
	a_unpowered_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !powered && !(out_valid && out_stall) |=> !out_valid)
		else $error("result appeared for an unpowered item");

	// A powered item with a free output shows its result once it has passed the compare stage and the output register.
	a_powered_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && powered && !out_valid |=> ##1 out_valid)
		else $error("powered item produced no result");

endmodule

bind fan_step_hysteresis_level fshl_checker #(
	.LEVELS (LEVELS)
) u_fshl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.powered    (powered),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.target_rpm (target_rpm),
	.fan_level  (fan_level)
);

FILE: verif/fshl_checker.sv
// Checker that predicts the fan level of every powered reading and compares the results.
module fshl_scoreboard #(
	parameter int LEVELS = fshl_pkg::LEVELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	input  logic                            in_stall,
	input  fshl_pkg::temp_t                 cpu_temp,
	input  fshl_pkg::temp_t                 temp_regulator,
	input  fshl_pkg::temp_t                 charger_temp,
	input  logic                            powered,

	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [fshl_pkg::RPM_W-1:0]      target_rpm,
	input  logic [fshl_pkg::LEVEL_W-1:0]    fan_level,

	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fshl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fshl_pkg::CFG_DATA_W-1:0] cfg_data,

	output int                              mismatches,
	output int                              open_count
);
	import fshl_pkg::*;

	typedef struct packed {
		rpm_t               rpm;
		logic [LEVEL_W-1:0] level;
	} fan_result_t;

	fan_result_t due_results[$];

	// Shadow of the level registers; entries past the written table stay zero.
	level_word_t curve_regs [0:(1 << LEVEL_W) - 1];
	int          cur_level;
	int          last_reading [0:2];

	function automatic int thr_byte(input level_word_t w, input int lsb);
		logic signed [BYTE_W-1:0] b;
		b = w[lsb +: BYTE_W];
		return b;
	endfunction

	// Walks the level from its current value for one new reading.
	function automatic int walk_level(input int tc, input int tr, input int tg);
		int   lv;
		logic fell;
		logic rose;
		lv   = cur_level;
		fell = tc < last_reading[0] || tr < last_reading[1] || tg < last_reading[2];
		rose = tc > last_reading[0] || tr > last_reading[1] || tg > last_reading[2];
		if (fell) begin
			while (lv > 0 &&
			       tc < thr_byte(curve_regs[lv], OFF_CPU_LSB) &&
			       tr < thr_byte(curve_regs[lv], OFF_REG_LSB) &&
			       tg < thr_byte(curve_regs[lv], OFF_CHG_LSB))
				lv--;
		end else if (rose) begin
			while (lv < LEVELS &&
			       (tc > thr_byte(curve_regs[lv & 7], ON_CPU_LSB) ||
			        (tr > thr_byte(curve_regs[lv & 7], ON_REG_LSB) &&
			         tg > thr_byte(curve_regs[lv & 7], ON_CHG_LSB))))
				lv++;
		end
		if (lv >= LEVELS)
			lv = LEVELS - 1;
		return lv & 7;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < (1 << LEVEL_W); i++)
				curve_regs[i] = '0;
			cur_level = 0;
			for (int s = 0; s < 3; s++)
				last_reading[s] = 0;
			due_results.delete();
			mismatches = 0;
			open_count = 0;
		end else begin : watch
			fan_result_t want;
			int          tc;
			int          tr;
			int          tg;
			int          nl;
			// Results leave only after their item has passed the compare stage, so check them first.
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: expected none, got rpm %0d level %0d",
						         target_rpm, fan_level);
				end else begin
					want = due_results.pop_front();
					if (target_rpm !== want.rpm || fan_level !== want.level) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected rpm %0d level %0d, ",
							          "got rpm %0d level %0d"},
							         want.rpm, want.level, target_rpm, fan_level);
					end
				end
			end
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS && cfg_index < LEVELS)
				curve_regs[cfg_index] = cfg_data;
			if (in_valid && !in_stall && powered === 1'b1) begin
				tc = cpu_temp;
				tr = temp_regulator;
				tg = charger_temp;
				nl = walk_level(tc, tr, tg);
				cur_level       = nl;
				last_reading[0] = tc;
				last_reading[1] = tr;
				last_reading[2] = tg;
				want.level = nl[LEVEL_W-1:0];
				want.rpm   = curve_regs[nl][RPM_LSB +: RPM_W];
				due_results.push_back(want);
			end
			open_count = due_results.size();
		end
	end

endmodule

FILE: verif/tb.sv
// Top of the fan level testbench: clock, reset, stimulus, curve settings and the verdict.
module tb;
	import fshl_pkg::*;

	localparam int LEVELS       = LEVELS_DEF;
	localparam int PHASE_ITEMS  = 180;
	localparam int SETTLE_CYC   = 8;

	// Kinds of level curves loaded between phases.
	typedef enum int {
		CURVE_LADDER,
		CURVE_ONES,
		CURVE_HOT,
		CURVE_COLD,
		CURVE_RANDOM
	} curve_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	temp_t                 cpu_temp;
	temp_t                 temp_regulator;
	temp_t                 charger_temp;
	logic                  powered;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [RPM_W-1:0]      target_rpm;
	logic [LEVEL_W-1:0]    fan_level;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int open_count;

	// When set, neither the sender nor the receiver idles.
	bit quiet = 1'b0;

	// Last powered reading sent, the base for small steps and repeats.
	int last_c = 0;
	int last_r = 0;
	int last_g = 0;

	level_word_t curve_set [0:NUM_REGS-1];

	curve_kind_t phase_plan [0:6] = '{CURVE_LADDER, CURVE_ONES, CURVE_HOT, CURVE_COLD,
	                                  CURVE_RANDOM, CURVE_LADDER, CURVE_LADDER};

	fan_step_hysteresis_level #(.LEVELS(LEVELS)) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cpu_temp       (cpu_temp),
		.temp_regulator (temp_regulator),
		.charger_temp   (charger_temp),
		.powered        (powered),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_rpm     (target_rpm),
		.fan_level      (fan_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	fshl_scoreboard #(.LEVELS(LEVELS)) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cpu_temp       (cpu_temp),
		.temp_regulator (temp_regulator),
		.charger_temp   (charger_temp),
		.powered        (powered),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_rpm     (target_rpm),
		.fan_level      (fan_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.open_count     (open_count)
	);

	always #1 clk = ~clk;

	// The receiver stalls about a third of the cycles, except in the quiet stretch.
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 34);
	end

	// Packs one level register, clipping every threshold to a signed byte.
	function automatic level_word_t pack_level(input int on_c, input int on_r, input int on_g,
	                                           input int off_c, input int off_r, input int off_g,
	                                           input int rpm);
		int          f [0:5];
		int          v;
		level_word_t w;
		f[0] = on_c;
		f[1] = on_r;
		f[2] = on_g;
		f[3] = off_c;
		f[4] = off_r;
		f[5] = off_g;
		w = '0;
		for (int i = 0; i < 6; i++) begin
			v = f[i];
			if (v > 127)
				v = 127;
			if (v < -128)
				v = -128;
			w[i*BYTE_W +: BYTE_W] = v[BYTE_W-1:0];
		end
		w[RPM_LSB +: RPM_W] = rpm[RPM_W-1:0];
		return w;
	endfunction

	// Picks one temperature: mostly near the previous value or within the threshold span,
	// sometimes at the extremes of the field or anywhere in it.
	function automatic int pick_temp(input int prev);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 15)
			v = prev;
		else if (r < 45)
			v = prev + $urandom_range(0, 20) - 10;
		else if (r < 85)
			v = $urandom_range(0, 300) - 150;
		else if (r < 92)
			v = $urandom_range(0, 1) ? 511 : -512;
		else
			v = $urandom_range(0, 1023) - 512;
		if (v > 511)
			v = 511;
		if (v < -512)
			v = -512;
		return v;
	endfunction

	// Fills the curve with a rising ladder of on points and off points a bit below them,
	// so that random readings walk the level up and down across the whole table.
	task automatic fill_ladder();
		int base;
		int stride;
		int on_c;
		int on_r;
		int on_g;
		base   = $urandom_range(0, 60) - 120;
		stride = $urandom_range(5, 40);
		for (int i = 0; i < NUM_REGS; i++) begin
			on_c = base + i * stride + $urandom_range(0, 10);
			on_r = base + i * stride + $urandom_range(0, 20);
			on_g = base + i * stride + $urandom_range(0, 20);
			curve_set[i] = pack_level(on_c, on_r, on_g,
			                          on_c - $urandom_range(0, 25),
			                          on_r - $urandom_range(0, 25),
			                          on_g - $urandom_range(0, 25),
			                          i * 1500 + $urandom_range(0, 1000));
		end
	endtask

	task automatic choose_curve(input curve_kind_t kind);
		for (int i = 0; i < NUM_REGS; i++) begin
			case (kind)
				CURVE_ONES: begin
					curve_set[i] = '1;
				end
				CURVE_HOT: begin
					curve_set[i] = pack_level(127, 127, 127, 127, 127, 127, $urandom);
				end
				CURVE_COLD: begin
					curve_set[i] = pack_level(-128, -128, -128, -128, -128, -128, $urandom);
				end
				CURVE_RANDOM: begin
					curve_set[i] = {$urandom, $urandom};
				end
				default: begin
					curve_set[i] = '0;
				end
			endcase
		end
		if (kind == CURVE_LADDER)
			fill_ladder();
	endtask

	// Writes every level register, then one index past the table that must be ignored.
	// Called at a falling edge while the block is idle.
	task automatic load_curve();
		for (int i = 0; i <= NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= (i < NUM_REGS) ? curve_set[i] : {$urandom, $urandom};
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Sends one item and returns at the falling edge after it was taken. Valid and the
	// payload stay put while the block stalls.
	task automatic send_reading(input int tc, input int tr, input int tg, input bit pw);
		while (!quiet && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		cpu_temp       <= tc[TEMP_W-1:0];
		temp_regulator <= tr[TEMP_W-1:0];
		charger_temp   <= tg[TEMP_W-1:0];
		powered        <= pw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (pw) begin
			last_c = tc;
			last_r = tr;
			last_g = tg;
		end
	endtask

	// Holds the sender off until every expected result has come, then lets the
	// block finish any unpowered item that is still passing through.
	task automatic settle();
		in_valid <= 1'b0;
		while (open_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	initial begin : stimulus
		int tc;
		int tr;
		int tg;
		bit pw;
		int sent;
		int guard;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cpu_temp       = '0;
		temp_regulator = '0;
		charger_temp   = '0;
		powered        = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With the reset curve every threshold is zero and every rpm is zero.
		send_reading(0, 0, 0, 1'b1);         // same as the stored reading: level holds
		send_reading(511, 511, 511, 1'b0);   // not powered: no result, no state change
		send_reading(5, 0, 0, 1'b1);         // cpu rises past every on point: clamps at top
		send_reading(5, 0, 0, 1'b1);         // unchanged at the top level
		settle();

		// A fixed ladder with known points for the hand-picked cases below.
		for (int i = 0; i < NUM_REGS; i++)
			curve_set[i] = pack_level(20 + 10 * i, 30 + 10 * i, 30 + 10 * i,
			                          10 + 10 * i, 20 + 10 * i, 20 + 10 * i, 1000 * (i + 1));
		load_curve();
		@(negedge clk);

		send_reading(-512, -512, -512, 1'b1); // everything falls to the bottom
		send_reading(35, 0, 0, 1'b1);         // cpu alone walks up two levels
		send_reading(35, 50, 0, 1'b1);        // only the regulator rises: no step
		send_reading(35, 65, 65, 1'b1);       // regulator and charger together step up
		send_reading(36, 60, 66, 1'b1);       // one falls while others rise: falling wins
		send_reading(36, 59, 66, 1'b1);       // charger still above its off point: holds
		send_reading(30, 40, 40, 1'b1);       // all below the off points: walks down
		send_reading(511, 511, 511, 1'b1);    // field maximum: walks past the top
		send_reading(511, 511, 511, 1'b1);
		send_reading(0, 0, 0, 1'b0);
		send_reading(-1, -1, -1, 1'b1);
		send_reading(-512, 511, -512, 1'b1);
		send_reading(511, -512, 511, 1'b1);
		send_reading(-512, 511, 511, 1'b1);
		settle();

		// Random phases, each with its own curve. One phase runs with no idling at all.
		for (int ph = 0; ph < 7; ph++) begin
			choose_curve(phase_plan[ph]);
			load_curve();
			quiet <= (ph == 5);
			@(negedge clk);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 8) begin
					tc = last_c;
					tr = last_r;
					tg = last_g;
				end else begin
					tc = pick_temp(last_c);
					tr = pick_temp(last_r);
					tg = pick_temp(last_g);
				end
				pw = ($urandom_range(0, 99) < 88);
				send_reading(tc, tr, tg, pw);
				if (pw)
					sent++;
				// Now and then, and once for sure, the sender waits for all results.
				if ($urandom_range(0, 199) == 0 || (ph == 2 && pw && sent == PHASE_ITEMS / 2))
					settle();
			end
			settle();
			quiet <= 1'b0;
		end

		in_valid <= 1'b0;
		guard = 0;
		while (open_count != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (2 * SETTLE_CYC) @(negedge clk);

		if (mismatches == 0 && open_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
